/* rtl/fcr_pkg.sv */
// Shared constants, codes and types of the FAT16 cluster chain reader.
package fcr_pkg;

   localparam int DATA_CLUSTERS = 1024;
   localparam int SECTOR_BYTES = 512;
   localparam int TABLE_DEPTH = DATA_CLUSTERS + 2;
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int EPOCH_W = 8;

   localparam logic [15:0] END_OF_CHAIN = 16'hFFF8;
   localparam logic [15:0] FIRST_DATA_CLUSTER = 16'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_WALK = 1'b1;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_SIZE = 3'd1;
   localparam logic [2:0] ST_RANGE = 3'd2;
   localparam logic [2:0] ST_LOOP = 3'd3;
   localparam logic [2:0] ST_SHORT = 3'd4;

   typedef struct packed {
      logic [31:0] bytes_read;
      logic [2:0]  status;
      logic [15:0] clusters_visited;
   } result_type;

endpackage

/* rtl/fcr_ram.sv */
// Generic single-port-write, registered-read RAM.
module fcr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1026
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/fcr_walk.sv */
// Table and visited-tag memories with the chain walk sequencer.
module fcr_walk (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [15:0]        req_entry_index,
   input  logic [15:0]        req_entry_value,
   input  logic [15:0]        req_start_cluster,
   input  logic [31:0]        req_file_size,
   input  logic [31:0]        req_dest_capacity,
   input  logic               slot_free,
   output logic               res_done,
   output fcr_pkg::result_type res
);
   import fcr_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_CHECK  = 5'b00100,
      S_READ   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [15:0]         cl_ff, cl_in;
   logic [31:0]         remain_ff, remain_in;
   logic [31:0]         size_ff, size_in;
   logic [15:0]         count_ff, count_in;
   logic [2:0]          status_ff, status_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic                clr_table_ff, clr_table_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;

   logic                tbl_wr_en;
   logic [ADDR_W-1:0]   tbl_wr_addr;
   logic [15:0]         tbl_wr_data;
   logic [15:0]         tbl_rd_data;
   logic                tag_wr_en;
   logic [ADDR_W-1:0]   tag_wr_addr;
   logic [EPOCH_W-1:0]  tag_wr_data;
   logic [EPOCH_W-1:0]  tag_rd_data;
   logic                accept;
   logic                in_range;

   assign accept = req_valid && (state_ff == S_IDLE);
   assign in_range = (cl_ff >= FIRST_DATA_CLUSTER) && (cl_ff < 16'(TABLE_DEPTH));

   fcr_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (cl_ff[ADDR_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   fcr_ram #(.WIDTH(EPOCH_W), .DEPTH(TABLE_DEPTH)) u_tags (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data),
      .rd_addr (cl_ff[ADDR_W-1:0]),
      .rd_data (tag_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      cl_in        = cl_ff;
      remain_in    = remain_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      clr_addr_in  = clr_addr_ff;
      clr_table_in = clr_table_ff;
      epoch_in     = epoch_ff;
      tbl_wr_en    = 1'b0;
      tbl_wr_addr  = clr_addr_ff;
      tbl_wr_data  = '0;
      tag_wr_en    = 1'b0;
      tag_wr_addr  = clr_addr_ff;
      tag_wr_data  = '0;
      unique case (state_ff)
         S_CLEAR: begin
            tbl_wr_en = clr_table_ff;
            tag_wr_en = 1'b1;
            if (clr_addr_ff == ADDR_W'(TABLE_DEPTH - 1)) begin
               clr_addr_in  = '0;
               clr_table_in = 1'b0;
               epoch_in     = EPOCH_W'(1);
               state_in     = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_LOAD) begin
                  tbl_wr_en   = (req_entry_index < 16'(TABLE_DEPTH));
                  tbl_wr_addr = req_entry_index[ADDR_W-1:0];
                  tbl_wr_data = req_entry_value;
               end else begin
                  count_in  = '0;
                  size_in   = req_file_size;
                  remain_in = req_file_size;
                  cl_in     = req_start_cluster;
                  if ((req_file_size == '0) || (req_file_size > req_dest_capacity)) begin
                     status_in = ST_SIZE;
                     state_in  = S_FINISH;
                  end else begin
                     state_in = S_CHECK;
                  end
               end
            end
         end
         S_CHECK: begin
            if (in_range) begin
               state_in = S_READ;
            end else begin
               status_in = ST_RANGE;
               state_in  = S_FINISH;
            end
         end
         S_READ: begin
            if (tag_rd_data == epoch_ff) begin
               status_in = ST_LOOP;
               state_in  = S_FINISH;
            end else begin
               tag_wr_en   = 1'b1;
               tag_wr_addr = cl_ff[ADDR_W-1:0];
               tag_wr_data = epoch_ff;
               count_in    = count_ff + 1'b1;
               if (remain_ff <= 32'(SECTOR_BYTES)) begin
                  status_in = ST_OK;
                  state_in  = S_FINISH;
               end else if (tbl_rd_data >= END_OF_CHAIN) begin
                  status_in = ST_SHORT;
                  state_in  = S_FINISH;
               end else begin
                  remain_in = remain_ff - 32'(SECTOR_BYTES);
                  cl_in     = tbl_rd_data;
                  state_in  = S_CHECK;
               end
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               if (epoch_ff == '1) begin
                  clr_addr_in = '0;
                  state_in    = S_CLEAR;
               end else begin
                  epoch_in = epoch_ff + 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_table_ff <= 1'b1;
         epoch_ff     <= EPOCH_W'(1);
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_table_ff <= clr_table_in;
         epoch_ff     <= epoch_in;
      end
      cl_ff     <= cl_in;
      remain_ff <= remain_in;
      size_ff   <= size_in;
      count_ff  <= count_in;
      status_ff <= status_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign res_done = (state_ff == S_FINISH) && slot_free;
   assign res.bytes_read = (status_ff == ST_OK) ? size_ff : '0;
   assign res.status = status_ff;
   assign res.clusters_visited = count_ff;

endmodule

/* rtl/fat16_cluster_chain_reader_core.sv */
// Top level of the FAT16 cluster chain reader: walk engine and result register.
//
//  channel  direction  handshake              payload
//  req_     in         req_valid / req_stall  operation, entry_index, entry_value,
//                                             start_cluster, file_size, dest_capacity
//  rsp_     out        rsp_valid / rsp_stall  bytes_read, status, clusters_visited
//
// A load item writes its entry into the table when accepted; indices beyond the table are
// dropped. A walk takes a range check with table and tag read, then a loop check and tag
// write, for each cluster examined; a cluster out of range ends the walk at the range check.
// After reset the table and tag memories are swept over all 1026 entries; every 255 walks
// the tag memory is swept again. No item is taken during a sweep.
// A finished result waits in the output register; the next item is taken meanwhile,
// and a following walk holds at its end until that register is free.
module fat16_cluster_chain_reader_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_entry_index,
   input  logic [15:0] req_entry_value,
   input  logic [15:0] req_start_cluster,
   input  logic [31:0] req_file_size,
   input  logic [31:0] req_dest_capacity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_bytes_read,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_clusters_visited
);
   import fcr_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   logic       slot_free;
   logic       res_done;
   result_type res;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   fcr_walk u_walk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .req_start_cluster (req_start_cluster),
      .req_file_size     (req_file_size),
      .req_dest_capacity (req_dest_capacity),
      .slot_free         (slot_free),
      .res_done          (res_done),
      .res               (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (slot_free) begin
         rsp_valid_in = res_done;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_bytes_read = rsp_data_ff.bytes_read;
   assign rsp_status = rsp_data_ff.status;
   assign rsp_clusters_visited = rsp_data_ff.clusters_visited;

   a_walk_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == OP_WALK) |=> req_stall)
      else $error("walk item did not start the sequencer");

   a_fail_zero_bytes: assert property (@(posedge clock) disable iff (reset)
      res_done && (res.status != ST_OK) |-> (res.bytes_read == '0))
      else $error("failed walk reports nonzero bytes");

   a_reject_no_clusters: assert property (@(posedge clock) disable iff (reset)
      res_done && (res.status == ST_SIZE) |-> (res.clusters_visited == '0))
      else $error("rejected walk reports visited clusters");

   a_ok_has_clusters: assert property (@(posedge clock) disable iff (reset)
      res_done && (res.status == ST_OK) |-> (res.clusters_visited != '0))
      else $error("successful walk visited no cluster");

endmodule

/* dv/tb_fat16_cluster_chain_reader_core.sv */
// Self-checking testbench for the FAT16 cluster chain reader: table loads, chain walks, checks.
module tb_fat16_cluster_chain_reader_core;
   timeunit 1ns;
   timeprecision 1ps;

   import fcr_pkg::*;

   localparam int ITEM_TARGET = 1850;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 100;
   localparam int MAX_REPORTS = 10;

   typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_LOAD;
   logic [15:0] req_entry_index = '0;
   logic [15:0] req_entry_value = '0;
   logic [15:0] req_start_cluster = '0;
   logic [31:0] req_file_size = '0;
   logic [31:0] req_dest_capacity = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_bytes_read;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_clusters_visited;

   logic [15:0] fat_table [TABLE_DEPTH];
   result_type  pending_results [$];

   int items_sent = 0;
   int loads_sent = 0;
   int walks_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int status_hits [8];

   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int unsigned    cycle_count = 0;

   fat16_cluster_chain_reader_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_entry_index      (req_entry_index),
      .req_entry_value      (req_entry_value),
      .req_start_cluster    (req_start_cluster),
      .req_file_size        (req_file_size),
      .req_dest_capacity    (req_dest_capacity),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_bytes_read       (rsp_bytes_read),
      .rsp_status           (rsp_status),
      .rsp_clusters_visited (rsp_clusters_visited)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic result_type predict_walk(input logic [15:0] first,
                                               input logic [31:0] size,
                                               input logic [31:0] cap);
      result_type             r;
      logic [TABLE_DEPTH-1:0] seen;
      logic [31:0]            covered;
      logic [31:0]            left;
      logic [31:0]            take;
      logic [15:0]            cl;
      logic [15:0]            nxt;
      logic [15:0]            count;
      bit                     stopped;
      bit                     at_end;
      seen = '0;
      covered = '0;
      count = '0;
      cl = first;
      stopped = 1'b0;
      at_end = 1'b0;
      r.bytes_read = '0;
      r.status = ST_OK;
      r.clusters_visited = '0;
      if (size == 0 || size > cap) begin
         r.status = ST_SIZE;
         return r;
      end
      while (!stopped && !at_end && covered < size) begin
         if (cl < FIRST_DATA_CLUSTER || cl >= TABLE_DEPTH) begin
            r.status = ST_RANGE;
            stopped = 1'b1;
         end else if (seen[cl]) begin
            r.status = ST_LOOP;
            stopped = 1'b1;
         end else begin
            seen[cl] = 1'b1;
            count++;
            left = size - covered;
            take = (left < SECTOR_BYTES) ? left : SECTOR_BYTES;
            covered += take;
            nxt = fat_table[cl];
            if (nxt >= END_OF_CHAIN) at_end = 1'b1;
            else cl = nxt;
         end
      end
      r.clusters_visited = count;
      if (!stopped) begin
         if (covered != size) r.status = ST_SHORT;
         else r.bytes_read = covered;
      end
      return r;
   endfunction

   function automatic logic [15:0] chain_cluster(input int base, input int stride, input int k);
      return 16'(FIRST_DATA_CLUSTER + ((base + k * stride) % DATA_CLUSTERS));
   endfunction

   function automatic logic [31:0] pick_capacity(input logic [31:0] size);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return 32'hFFFF_FFFF;
      if (pick < 7) return size + $urandom_range(0, 4096);
      if (pick == 7) return size;
      if (pick == 8) return size - 1;
      return $urandom;
   endfunction

   // Drive one item, hold it until accepted, then update the predictor.
   task automatic send_item(input logic op, input logic [15:0] idx, input logic [15:0] val,
                            input logic [15:0] first, input logic [31:0] size,
                            input logic [31:0] cap);
      int gap;
      req_valid <= 1'b1;
      req_operation <= op;
      req_entry_index <= idx;
      req_entry_value <= val;
      req_start_cluster <= first;
      req_file_size <= size;
      req_dest_capacity <= cap;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (op == OP_LOAD) begin
         if (idx < TABLE_DEPTH) begin
            fat_table[idx] = val;
         end
         loads_sent++;
      end else begin
         pending_results.push_back(predict_walk(first, size, cap));
         walks_sent++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 20);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic load_entry(input logic [15:0] idx, input logic [15:0] val);
      send_item(OP_LOAD, idx, val, 16'($urandom), $urandom, $urandom);
   endtask

   task automatic walk_file(input logic [15:0] first, input logic [31:0] size,
                            input logic [31:0] cap);
      send_item(OP_WALK, 16'($urandom), 16'($urandom), first, size, cap);
   endtask

   task automatic link_chain(input int base, input int stride, input int len,
                             input logic [15:0] tail);
      for (int k = 0; k < len; k++) begin
         load_entry(chain_cluster(base, stride, k),
                    (k == len - 1) ? tail : chain_cluster(base, stride, k + 1));
      end
   endtask

   // Hold the sender until every outstanding walk has reported.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic test_size_checks();
      walk_file(16'd2, 32'd0, 32'hFFFF_FFFF);
      walk_file(16'd2, 32'd1, 32'd0);
      walk_file(16'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
   endtask

   task automatic test_range_checks();
      load_entry(16'd0, 16'hFFFF);
      load_entry(16'd1, 16'd5);
      load_entry(16'(TABLE_DEPTH), 16'd7);
      load_entry(16'hFFFF, 16'hFFFF);
      walk_file(16'd0, 32'd100, 32'hFFFF_FFFF);
      walk_file(16'd1, 32'd100, 32'hFFFF_FFFF);
      walk_file(16'(TABLE_DEPTH), 32'd100, 32'hFFFF_FFFF);
      walk_file(16'hFFFF, 32'd100, 32'hFFFF_FFFF);
      walk_file(16'd2, 32'd513, 32'hFFFF_FFFF);
   endtask

   task automatic test_chain_endings();
      walk_file(16'd2, 32'd512, 32'd512);
      load_entry(16'd2, 16'd3);
      load_entry(16'd3, END_OF_CHAIN);
      walk_file(16'd2, 32'd1024, 32'hFFFF_FFFF);
      walk_file(16'd2, 32'd1025, 32'hFFFF_FFFF);
      load_entry(16'd3, 16'd2);
      walk_file(16'd2, 32'd2000, 32'd2000);
      load_entry(16'd3, 16'hFFF7);
      walk_file(16'd2, 32'd1500, 32'hFFFF_FFFF);
      load_entry(16'(TABLE_DEPTH - 1), 16'hFFFF);
      walk_file(16'(TABLE_DEPTH - 1), 32'd1, 32'd1);
      walk_file(16'(TABLE_DEPTH - 1), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_full_chain();
      int          base;
      int          stride;
      logic [31:0] span;
      base = $urandom_range(0, DATA_CLUSTERS - 1);
      stride = 2 * $urandom_range(0, DATA_CLUSTERS / 2 - 1) + 1;
      span = DATA_CLUSTERS * SECTOR_BYTES;
      link_chain(base, stride, DATA_CLUSTERS, END_OF_CHAIN + 16'($urandom_range(0, 7)));
      walk_file(chain_cluster(base, stride, 0), span, span);
      walk_file(chain_cluster(base, stride, 0), span + 1, 32'hFFFF_FFFF);
      walk_file(chain_cluster(base, stride, 0), span, span - 1);
      load_entry(chain_cluster(base, stride, DATA_CLUSTERS - 1), chain_cluster(base, stride, 0));
      walk_file(chain_cluster(base, stride, 0), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      walk_file(chain_cluster(base, stride, DATA_CLUSTERS / 2), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_random_chains();
      int          base;
      int          stride;
      int          len;
      int          kind;
      int          pick;
      int          start_k;
      int          seq;
      logic [15:0] tail;
      logic [15:0] first;
      logic [31:0] size;
      logic [31:0] span;
      seq = 0;
      while (items_sent < ITEM_TARGET) begin
         seq++;
         if (seq % 60 == 0) wait_for_results();
         kind = $urandom_range(0, 99);
         if (kind < 85) begin
            base = $urandom_range(0, DATA_CLUSTERS - 1);
            stride = 2 * $urandom_range(0, DATA_CLUSTERS / 2 - 1) + 1;
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            pick = $urandom_range(0, 99);
            if (pick < 60) tail = END_OF_CHAIN + 16'($urandom_range(0, 7));
            else if (pick < 70) tail = 16'h0000;
            else if (pick < 75) tail = 16'hFFF7;
            else if (pick < 80) tail = 16'($urandom_range(TABLE_DEPTH, 16'hFFF6));
            else if (pick < 85) tail = 16'h0001;
            else tail = chain_cluster(base, stride, $urandom_range(0, len - 1));
            link_chain(base, stride, len, tail);
            repeat ($urandom_range(1, 4)) begin
               start_k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : 0;
               span = (len - start_k) * SECTOR_BYTES;
               pick = $urandom_range(0, 9);
               if (pick < 4) size = span - $urandom_range(0, SECTOR_BYTES - 1);
               else if (pick < 6) size = $urandom_range(1, span);
               else if (pick < 8) size = span + $urandom_range(1, 3 * SECTOR_BYTES);
               else if (pick == 8) size = $urandom_range(1, 2);
               else size = $urandom;
               walk_file(chain_cluster(base, stride, start_k), size, pick_capacity(size));
            end
         end else if (kind < 93) begin
            if ($urandom_range(0, 1) == 0) begin
               load_entry(($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, TABLE_DEPTH - 1))
                                                      : 16'($urandom), 16'($urandom));
            end else begin
               first = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, TABLE_DEPTH - 1));
               size = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 4096);
               walk_file(first, size, ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FFFF);
            end
         end else begin
            first = 16'($urandom_range(FIRST_DATA_CLUSTER, TABLE_DEPTH - 1));
            load_entry(16'($urandom_range(FIRST_DATA_CLUSTER, TABLE_DEPTH - 1)), 16'($urandom));
            size = $urandom_range(1, 8 * SECTOR_BYTES);
            walk_file(first, size, pick_capacity(size));
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_COIN:     rsp_stall <= $urandom_range(0, 1);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 8);
         STALL_PERIODIC: rsp_stall <= (cycle_count[4:2] == 3'd0);
      endcase
   end

   always @(posedge clock) begin
      result_type want;
      if (reset == 1'b0 && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: result with none pending: bytes %0d status %0d clusters %0d",
                        rsp_bytes_read, rsp_status, rsp_clusters_visited);
         end else begin
            want = pending_results.pop_front();
            status_hits[want.status]++;
            if (rsp_bytes_read !== want.bytes_read || rsp_status !== want.status ||
                rsp_clusters_visited !== want.clusters_visited) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("ERROR: result %0d expected bytes %0d status %0d clusters %0d, got %s",
                           results_seen, want.bytes_read, want.status, want.clusters_visited,
                           $sformatf("bytes %0d status %0d clusters %0d", rsp_bytes_read,
                                     rsp_status, rsp_clusters_visited));
            end
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: %0d cycles with no item moving", IDLE_LIMIT);
      $display("fat16_cluster_chain_reader_core verification failed");
      $finish;
   end

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) fat_table[i] = '0;
      for (int i = 0; i < 8; i++) status_hits[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_size_checks();
      test_range_checks();
      test_chain_endings();
      test_full_chain();
      test_random_chains();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) mismatches++;
      $display("Covered %0d loads and %0d walks; %0d results checked, %0d mismatches.",
               loads_sent, walks_sent, results_seen, mismatches);
      $display("Walk outcomes: ok %0d, size %0d, range %0d, loop %0d, short %0d.",
               status_hits[ST_OK], status_hits[ST_SIZE], status_hits[ST_RANGE],
               status_hits[ST_LOOP], status_hits[ST_SHORT]);
      if (mismatches == 0) begin
         $display("fat16_cluster_chain_reader_core verification clean");
      end else begin
         $display("fat16_cluster_chain_reader_core verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/fcr_pkg.sv
rtl/fcr_ram.sv
rtl/fcr_walk.sv
rtl/fat16_cluster_chain_reader_core.sv
dv/tb_fat16_cluster_chain_reader_core.sv
